// File: sv/shd_pkg.sv
// Package for the security header decoder: constants, codes and shared types.
package shd_pkg;

  localparam int HEADER_BYTES = 12;
  localparam int CNT_W        = 34;

  localparam logic [7:0] MAGIC_F    = 8'h46;
  localparam logic [7:0] MAGIC_M    = 8'h4D;
  localparam logic [7:0] MAGIC_S    = 8'h53;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] NUL_BYTE   = 8'h00;

  localparam logic [7:0] MODE_NONE     = 8'd0;
  localparam logic [7:0] MODE_AUTH     = 8'd1;
  localparam logic [7:0] MODE_ACCEPTED = 8'd2;

  // header byte positions
  localparam logic [3:0] POS_MAGIC0   = 4'd0;
  localparam logic [3:0] POS_MAGIC1   = 4'd1;
  localparam logic [3:0] POS_MAGIC2   = 4'd2;
  localparam logic [3:0] POS_MAGIC3   = 4'd3;
  localparam logic [3:0] POS_MODE     = 4'd4;
  localparam logic [3:0] POS_ID_LEN   = 4'd5;
  localparam logic [3:0] POS_METH_LEN = 4'd6;
  localparam logic [3:0] POS_BIND_LEN = 4'd7;
  localparam logic [3:0] POS_SEC0     = 4'd8;
  localparam logic [3:0] POS_SEC1     = 4'd9;
  localparam logic [3:0] POS_SEC2     = 4'd10;
  localparam logic [3:0] POS_SEC3     = 4'd11;

  // configuration register indexes
  localparam logic [2:0] CFG_VERSION  = 3'd0;
  localparam logic [2:0] CFG_ID_LIM   = 3'd1;
  localparam logic [2:0] CFG_METH_LIM = 3'd2;
  localparam logic [2:0] CFG_SEC_LIM  = 3'd3;
  localparam logic [2:0] CFG_BINDING  = 3'd4;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    KIND_HEADER   = 3'd0,
    KIND_IDENTITY = 3'd1,
    KIND_METHOD   = 3'd2,
    KIND_BINDING  = 3'd3,
    KIND_SECRET   = 3'd4,
    KIND_EXCESS   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_PROTO = 2'd1,
    ST_SIZE  = 2'd2
  } status_t;

  typedef struct packed {
    logic [3:0]  version_digit;
    logic [7:0]  identity_limit;
    logic [7:0]  method_limit;
    logic [31:0] secret_limit;
    logic [7:0]  binding_size;
  } cfg_t;

  typedef struct packed {
    logic [7:0] echo_byte;
    kind_t      field_kind;
    logic       message_end;
    status_t    status;
    logic [7:0] mode_code;
  } result_t;

endpackage

// File: sv/shd_parser.sv
// Message state and per-byte decode: field tagging, header capture and final judgement.
module shd_parser
  import shd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_en,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       empty_message,
  input  cfg_t       cfg,
  output result_t    res
);

  cnt_t        count_r, count_nxt;
  logic        magic_r, magic_nxt;
  logic [7:0]  mode_r, mode_nxt;
  logic [7:0]  id_len_r, id_len_nxt;
  logic [7:0]  meth_len_r, meth_len_nxt;
  logic [7:0]  bind_len_r, bind_len_nxt;
  logic [31:0] sec_len_r, sec_len_nxt;
  logic        nul_r, nul_nxt;
  // running field end offsets, built with at most one add per header byte
  cnt_t        e1_r, e1_nxt;
  cnt_t        e2_r, e2_nxt;
  cnt_t        e3_r, e3_nxt;
  cnt_t        e4_r, e4_nxt;

  logic        in_hdr;
  logic [3:0]  pos;
  kind_t       kind;
  status_t     judge_st;
  logic [7:0]  judge_mode;
  logic        bind_ok;
  logic        rules_ok;

  always_comb begin
    in_hdr       = (count_r < CNT_W'(HEADER_BYTES));
    pos          = count_r[3:0];
    magic_nxt    = magic_r;
    mode_nxt     = mode_r;
    id_len_nxt   = id_len_r;
    meth_len_nxt = meth_len_r;
    bind_len_nxt = bind_len_r;
    sec_len_nxt  = sec_len_r;
    nul_nxt      = nul_r;
    e1_nxt       = e1_r;
    e2_nxt       = e2_r;
    e3_nxt       = e3_r;
    e4_nxt       = e4_r;

    if (in_hdr) begin
      kind = KIND_HEADER;
    end else if (count_r < e1_r) begin
      kind = KIND_IDENTITY;
    end else if (count_r < e2_r) begin
      kind = KIND_METHOD;
    end else if (count_r < e3_r) begin
      kind = KIND_BINDING;
    end else if (count_r < e4_r) begin
      kind = KIND_SECRET;
    end else begin
      kind = KIND_EXCESS;
    end

    if (in_hdr) begin
      case (pos)
        POS_MAGIC0: if (data_byte != MAGIC_F) magic_nxt = 1'b0;
        POS_MAGIC1: if (data_byte != MAGIC_M) magic_nxt = 1'b0;
        POS_MAGIC2: if (data_byte != MAGIC_S) magic_nxt = 1'b0;
        POS_MAGIC3: begin
          if (data_byte != ASCII_ZERO + {4'd0, cfg.version_digit}) magic_nxt = 1'b0;
        end
        POS_MODE:   mode_nxt   = data_byte;
        POS_ID_LEN: id_len_nxt = data_byte;
        POS_METH_LEN: begin
          meth_len_nxt = data_byte;
          e1_nxt       = CNT_W'(HEADER_BYTES) + CNT_W'(id_len_r);
        end
        POS_BIND_LEN: begin
          bind_len_nxt = data_byte;
          e2_nxt       = e1_r + CNT_W'(meth_len_r);
        end
        POS_SEC0: begin
          sec_len_nxt = {sec_len_r[23:0], data_byte};
          e3_nxt      = e2_r + CNT_W'(bind_len_r);
        end
        POS_SEC1, POS_SEC2: sec_len_nxt = {sec_len_r[23:0], data_byte};
        POS_SEC3: begin
          sec_len_nxt = {sec_len_r[23:0], data_byte};
          e4_nxt      = e3_r + CNT_W'(sec_len_nxt);
        end
        default: ;
      endcase
    end

    if ((kind == KIND_IDENTITY || kind == KIND_METHOD) && data_byte == NUL_BYTE) begin
      nul_nxt = 1'b1;
    end

    // saturating byte counter
    count_nxt = (&count_r) ? count_r : count_r + CNT_W'(1);

    // judgement on the closing byte, first failing rule wins
    bind_ok = (bind_len_nxt == 8'd0) || (bind_len_nxt == cfg.binding_size);
    case (mode_nxt)
      MODE_AUTH: rules_ok = (id_len_nxt != 8'd0) && (meth_len_nxt != 8'd0) &&
                            (sec_len_nxt != 32'd0) && bind_ok;
      MODE_ACCEPTED: rules_ok = (id_len_nxt == 8'd0) && (meth_len_nxt == 8'd0) &&
                                (sec_len_nxt == 32'd0) && bind_ok;
      default: rules_ok = 1'b0;
    endcase

    judge_st   = ST_PROTO;
    judge_mode = MODE_NONE;
    if (count_nxt >= CNT_W'(HEADER_BYTES) && magic_nxt && mode_nxt != MODE_NONE &&
        e4_nxt == count_nxt) begin
      if (id_len_nxt > cfg.identity_limit || meth_len_nxt > cfg.method_limit ||
          sec_len_nxt > cfg.secret_limit) begin
        judge_st = ST_SIZE;
      end else if (!nul_nxt && rules_ok) begin
        judge_st   = ST_OK;
        judge_mode = mode_nxt;
      end
    end

    if (empty_message) begin
      res.echo_byte   = 8'd0;
      res.field_kind  = KIND_HEADER;
      res.message_end = 1'b1;
      res.status      = ST_OK;
      res.mode_code   = MODE_NONE;
    end else begin
      res.echo_byte   = data_byte;
      res.field_kind  = kind;
      res.message_end = last_byte;
      res.status      = last_byte ? judge_st : ST_OK;
      res.mode_code   = last_byte ? judge_mode : MODE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      magic_r    <= 1'b1;
      mode_r     <= '0;
      id_len_r   <= '0;
      meth_len_r <= '0;
      bind_len_r <= '0;
      sec_len_r  <= '0;
      nul_r      <= 1'b0;
    end else if (item_en) begin
      if (empty_message || last_byte) begin
        count_r    <= '0;
        magic_r    <= 1'b1;
        mode_r     <= '0;
        id_len_r   <= '0;
        meth_len_r <= '0;
        bind_len_r <= '0;
        sec_len_r  <= '0;
        nul_r      <= 1'b0;
      end else begin
        count_r    <= count_nxt;
        magic_r    <= magic_nxt;
        mode_r     <= mode_nxt;
        id_len_r   <= id_len_nxt;
        meth_len_r <= meth_len_nxt;
        bind_len_r <= bind_len_nxt;
        sec_len_r  <= sec_len_nxt;
        nul_r      <= nul_nxt;
      end
    end
  end

  // edge offsets are rebuilt in every header before they are used
  always_ff @(posedge clk) begin
    if (item_en) begin
      e1_r <= e1_nxt;
      e2_r <= e2_nxt;
      e3_r <= e3_nxt;
      e4_r <= e4_nxt;
    end
  end

endmodule

// File: sv/security_header_decoder.sv
// Security header decoder top level: stream ports, configuration registers, result register.
// Throughput: one item per cycle while out_tready is high; the single result register is refilled while it drains.
// Header field ends are summed with at most one add per header byte, so no long adder chain per item.
// Reset (rst_n low, synchronous): message state cleared, output empty, configuration
// registers back to version 1, limits 255/255/65535 and binding size 32.
module security_header_decoder
  import shd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  input  logic [0:0]  in_tuser,   // [0] empty_message
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] echo_byte, [9:8] status, [17:10] mode_code, rest 0
  output logic        out_tlast,  // message_end
  output logic [2:0]  out_tuser,  // [2:0] field_kind
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t    cfg_r;
  result_t res;
  result_t res_r;
  logic    out_valid_r;
  logic    accept;

  // the output register frees as it is taken, so a new item enters in the same cycle
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.version_digit  <= 4'd1;
      cfg_r.identity_limit <= 8'd255;
      cfg_r.method_limit   <= 8'd255;
      cfg_r.secret_limit   <= 32'd65535;
      cfg_r.binding_size   <= 8'd32;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_VERSION:  cfg_r.version_digit  <= cfg_data[3:0];
        CFG_ID_LIM:   cfg_r.identity_limit <= cfg_data[7:0];
        CFG_METH_LIM: cfg_r.method_limit   <= cfg_data[7:0];
        CFG_SEC_LIM:  cfg_r.secret_limit   <= cfg_data;
        CFG_BINDING:  cfg_r.binding_size   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  shd_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_en       (accept),
    .data_byte     (in_tdata),
    .last_byte     (in_tlast),
    .empty_message (in_tuser[0]),
    .cfg           (cfg_r),
    .res           (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, res_r.mode_code, res_r.status, res_r.echo_byte};
  assign out_tlast  = res_r.message_end;
  assign out_tuser  = res_r.field_kind;

endmodule
